// ===== design/multibrot_escape_time_macros.svh =====
// ----------------------------------------------------------------------------
// multibrot_escape_time_macros.svh
// assertion macros shared by the escape time block
// ----------------------------------------------------------------------------
`ifndef MULTIBROT_ESCAPE_TIME_MACROS_SVH
`define MULTIBROT_ESCAPE_TIME_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define MBE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define MBE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/mbe_pkg.sv =====
// ----------------------------------------------------------------------------
// mbe_pkg
// types, constants and fixed point helpers of the escape time block
// ----------------------------------------------------------------------------
`default_nettype none

package mbe_pkg;

    localparam int MAX_ITER_DEF   = 500;
    localparam int PIXEL_BITS_DEF = 12;

    localparam int FRAC_BITS = 44;
    localparam int ZW        = 57;   // Q12.44 working width, sign included
    localparam int PW        = 112;  // full product magnitude
    localparam int ADDR_W    = 6;
    localparam int DATA_W    = 64;

    // register indexes
    localparam logic [2:0] REG_X_MIN  = 3'd0;
    localparam logic [2:0] REG_X_STEP = 3'd1;
    localparam logic [2:0] REG_Y_MAX  = 3'd2;
    localparam logic [2:0] REG_Y_STEP = 3'd3;
    localparam logic [2:0] REG_MODE   = 3'd4;
    localparam logic [2:0] MODE_MAX   = 3'd4;

    localparam logic signed [57:0] WIDE_LIM58 = {2'b00, {56{1'b1}}};
    localparam logic signed [57:0] WIDE_NEG58 = -WIDE_LIM58;
    localparam logic signed [57:0] ESC_LIM    = 58'sd4 <<< FRAC_BITS;
    localparam logic signed [64:0] C_MAX      = {18'd0, {47{1'b1}}};
    localparam logic signed [64:0] C_MIN      = -C_MAX - 65'sd1;

    typedef struct packed {
        logic signed [47:0] x_min;
        logic [46:0]        x_step;
        logic signed [47:0] y_max;
        logic [46:0]        y_step;
        logic [2:0]         power_mode;
    } cfg_t;

    // product magnitude back to Q12.44: drop fraction, saturate, apply sign
    function automatic logic signed [ZW-1:0] fix_post(input logic [PW-1:0] mag,
                                                      input logic neg);
        logic [55:0] r;
        r = (|mag[PW-1:100]) ? {56{1'b1}} : mag[99:44];
        return neg ? -$signed({1'b0, r}) : $signed({1'b0, r});
    endfunction

    // saturating sum of two Q12.44 words
    function automatic logic signed [ZW-1:0] sat_add(input logic signed [ZW-1:0] a,
                                                     input logic signed [ZW-1:0] b);
        logic signed [57:0] s;
        s = 58'(a) + 58'(b);
        if (s > WIDE_LIM58)
            s = WIDE_LIM58;
        else if (s < WIDE_NEG58)
            s = WIDE_NEG58;
        return s[ZW-1:0];
    endfunction

    // clamp a coordinate to the Q3.44 range, widened to the working format
    function automatic logic signed [ZW-1:0] clamp_c(input logic signed [64:0] s);
        logic signed [64:0] r;
        r = s;
        if (s > C_MAX)
            r = C_MAX;
        else if (s < C_MIN)
            r = C_MIN;
        return r[ZW-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/multibrot_escape_time.sv =====
// ----------------------------------------------------------------------------
// multibrot_escape_time
// escape time count of one pixel for z <- z^d + c, d = 2..6
// ----------------------------------------------------------------------------
// usage:
//   the in channel carries one word per pixel (pixel_col, pixel_row); the out
//   channel returns one word, escape_count, per pixel in order. both use
//   valid/ready. window and power are to be set over the apb port only while
//   idle; the block itself does not enforce it. one pixel is worked at a time;
//   in_ready is low from acceptance until the count is loaded into the output
//   register. all products run through one 28x28 multiplier, each taken as
//   issue, four partial products and result. mapping c costs 2 products;
//   each step costs 4*(d-1) + 2 products plus one pass through the add state;
//   a pixel takes up to MAX_ITER+1 steps. an unused power mode skips the
//   steps and answers with count zero.
//   reset clears the apb registers to zero and empties the output register.
//   a stalled receiver holds the finished count in the output register; the
//   next pixel then runs up to its end and waits there for the slot to free.
// ----------------------------------------------------------------------------
`default_nettype none

module multibrot_escape_time #(
    parameter int MAX_ITER   = mbe_pkg::MAX_ITER_DEF,
    parameter int PIXEL_BITS = mbe_pkg::PIXEL_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [mbe_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [mbe_pkg::DATA_W-1:0]  pwdata,
    output logic [mbe_pkg::DATA_W-1:0]       prdata,
    output logic                             pready,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [PIXEL_BITS-1:0]       pixel_col,
    input  wire logic [PIXEL_BITS-1:0]       pixel_row,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [8:0]                       escape_count
);
    import mbe_pkg::*;

`include "multibrot_escape_time_macros.svh"

    localparam int H_W = $clog2(MAX_ITER + 2);
    localparam logic [H_W-1:0] H_LAST = H_W'(MAX_ITER + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_CX, S_CY, S_POW, S_ADD, S_SQ, S_DONE
    } state_t;

    cfg_t    cfg;
    state_t  state_reg, state_next;

    logic [PIXEL_BITS-1:0]  px_reg, px_next, py_reg, py_next;
    logic signed [ZW-1:0]   cx_reg, cx_next, cy_reg, cy_next;
    logic signed [ZW-1:0]   x_reg, x_next, y_reg, y_next;
    logic signed [ZW-1:0]   pr_reg, pr_next, pi_reg, pi_next;
    logic signed [ZW-1:0]   t_reg, t_next, nr_reg, nr_next;
    logic [1:0]             idx_reg, idx_next;
    logic [2:0]             k_reg, k_next;
    logic [H_W-1:0]         h_reg, h_next;
    logic [8:0]             cnt_reg, cnt_next;
    logic                   ov_reg, ov_next;
    logic [8:0]             oc_reg, oc_next;

    logic                   mul_start, mul_busy, mul_done, mul_neg;
    logic [PW-1:0]          mul_mag;
    logic signed [ZW-1:0]   op_a, op_b, fp;
    logic signed [57:0]     mag_sum;
    logic                   in_fire, out_fire;

    mbe_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mbe_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (op_a),
        .b     (op_b),
        .busy  (mul_busy),
        .done  (mul_done),
        .mag   (mul_mag),
        .neg   (mul_neg)
    );

    assign in_ready     = (state_reg == S_IDLE);
    assign in_fire      = in_valid && in_ready;
    assign out_valid    = ov_reg;
    assign escape_count = oc_reg;
    assign out_fire     = ov_reg && out_ready;

    // multiplier issue whenever a product state has none in flight
    assign mul_start = (state_reg == S_CX || state_reg == S_CY || state_reg == S_POW ||
                        state_reg == S_SQ) && !mul_busy && !mul_done;

    // operand select
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (state_reg)
            S_CX:
            begin
                op_a = ZW'(px_reg);
                op_b = ZW'(cfg.x_step);
            end
            S_CY:
            begin
                op_a = ZW'(py_reg);
                op_b = ZW'(cfg.y_step);
            end
            S_POW:
            begin
                op_a = idx_reg[0] ? pi_reg : pr_reg;
                op_b = (idx_reg == 2'd1 || idx_reg == 2'd2) ? y_reg : x_reg;
            end
            S_SQ:
            begin
                op_a = idx_reg[0] ? y_reg : x_reg;
                op_b = idx_reg[0] ? y_reg : x_reg;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign fp      = fix_post(mul_mag, mul_neg);
    assign mag_sum = 58'(t_reg) + 58'(fp);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        px_next = px_reg;  py_next = py_reg;
        cx_next = cx_reg;  cy_next = cy_reg;
        x_next  = x_reg;   y_next  = y_reg;
        pr_next = pr_reg;  pi_next = pi_reg;
        t_next  = t_reg;   nr_next = nr_reg;
        idx_next = idx_reg;
        k_next  = k_reg;
        h_next  = h_reg;
        cnt_next = cnt_reg;
        ov_next = ov_reg && !out_ready;
        oc_next = oc_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    px_next  = pixel_col;
                    py_next  = pixel_row;
                    idx_next = '0;
                    cnt_next = '0;
                    state_next = (cfg.power_mode > MODE_MAX) ? S_DONE : S_CX;
                end
            end
            S_CX:
            begin
                if (mul_done)
                begin
                    cx_next = clamp_c(65'(cfg.x_min) + $signed({2'b00, mul_mag[62:0]}));
                    state_next = S_CY;
                end
            end
            S_CY:
            begin
                if (mul_done)
                begin
                    cy_next = clamp_c(65'(cfg.y_max) - $signed({2'b00, mul_mag[62:0]}));
                    x_next  = '0;
                    y_next  = '0;
                    pr_next = '0;
                    pi_next = '0;
                    k_next  = 3'd1;
                    h_next  = H_W'(1);
                    idx_next = '0;
                    state_next = S_POW;
                end
            end
            S_POW:
            begin
                if (mul_done)
                begin
                    idx_next = idx_reg + 2'd1;
                    case (idx_reg)
                        2'd0: t_next  = fp;
                        2'd1: nr_next = sat_add(t_reg, -fp);
                        2'd2: t_next  = fp;
                        default:
                        begin
                            pr_next = nr_reg;
                            pi_next = sat_add(t_reg, fp);
                            if (k_reg == cfg.power_mode + 3'd1)
                                state_next = S_ADD;
                            else
                                k_next = k_reg + 3'd1;
                        end
                    endcase
                end
            end
            S_ADD:
            begin
                x_next = sat_add(pr_reg, cx_reg);
                y_next = sat_add(pi_reg, cy_reg);
                idx_next = '0;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                if (mul_done)
                begin
                    if (idx_reg == 2'd0)
                    begin
                        t_next   = fp;
                        idx_next = 2'd1;
                    end
                    else
                    begin
                        idx_next = '0;
                        if (mag_sum > ESC_LIM)
                        begin
                            cnt_next = (h_reg == H_LAST) ? 9'd0 : 9'(h_reg);
                            state_next = S_DONE;
                        end
                        else if (h_reg == H_LAST)
                        begin
                            cnt_next = '0;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            h_next  = h_reg + H_W'(1);
                            pr_next = x_reg;
                            pi_next = y_reg;
                            k_next  = 3'd1;
                            state_next = S_POW;
                        end
                    end
                end
            end
            S_DONE:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next = 1'b1;
                    oc_next = cnt_reg;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        px_reg <= px_next;  py_reg <= py_next;
        cx_reg <= cx_next;  cy_reg <= cy_next;
        x_reg  <= x_next;   y_reg  <= y_next;
        pr_reg <= pr_next;  pi_reg <= pi_next;
        t_reg  <= t_next;   nr_reg <= nr_next;
        k_reg  <= k_next;
        h_reg  <= h_next;
        cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            ov_reg    <= 1'b0;
            oc_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            ov_reg    <= ov_next;
            oc_reg    <= oc_next;
        end
    end

    // checks
    `MBE_ASSERT_NEXT(a_busy_after_accept, in_fire, !in_ready,
        "block took a word while still working")
    `MBE_ASSERT_NOW(a_done_in_mul_state, mul_done,
        state_reg == S_CX || state_reg == S_CY || state_reg == S_POW || state_reg == S_SQ,
        "product finished outside a product state")
    `MBE_ASSERT_NEXT(a_out_drains, out_fire && state_reg != S_DONE, !out_valid,
        "output word repeated after it was taken")

endmodule

`default_nettype wire

// ===== design/mbe_regs.sv =====
// ----------------------------------------------------------------------------
// mbe_regs
// apb register file: window corner, pixel steps and power mode
// ----------------------------------------------------------------------------
`default_nettype none

module mbe_regs (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [mbe_pkg::ADDR_W-1:0] paddr,
    input  wire logic [mbe_pkg::DATA_W-1:0] pwdata,
    output logic [mbe_pkg::DATA_W-1:0]      prdata,
    output logic                            pready,
    output mbe_pkg::cfg_t                   cfg
);
    import mbe_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] idx;
    logic       wr_en;

    assign idx   = paddr[5:3];
    assign wr_en = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg   = cfg_reg;

    // write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_X_MIN:  cfg_next.x_min      = pwdata[47:0];
                REG_X_STEP: cfg_next.x_step     = pwdata[46:0];
                REG_Y_MAX:  cfg_next.y_max      = pwdata[47:0];
                REG_Y_STEP: cfg_next.y_step     = pwdata[46:0];
                REG_MODE:   cfg_next.power_mode = pwdata[2:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (idx)
            REG_X_MIN:  prdata = 64'(cfg_reg.x_min);
            REG_X_STEP: prdata = 64'(cfg_reg.x_step);
            REG_Y_MAX:  prdata = 64'(cfg_reg.y_max);
            REG_Y_STEP: prdata = 64'(cfg_reg.y_step);
            REG_MODE:   prdata = 64'(cfg_reg.power_mode);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

endmodule

`default_nettype wire

// ===== design/mbe_mul.sv =====
// ----------------------------------------------------------------------------
// mbe_mul
// shared multiplier: 56x56 magnitude product from four 28x28 partial products
// ----------------------------------------------------------------------------
`default_nettype none

module mbe_mul (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic signed [mbe_pkg::ZW-1:0] a,
    input  wire logic signed [mbe_pkg::ZW-1:0] b,
    output logic                             busy,
    output logic                             done,
    output logic [mbe_pkg::PW-1:0]           mag,
    output logic                             neg
);
    import mbe_pkg::*;

    logic [55:0]   am_reg, bm_reg;
    logic          neg_reg;
    logic [PW-1:0] acc_reg;
    logic [1:0]    cnt_reg;
    logic          busy_reg, done_reg;
    logic [ZW-1:0] a_abs, b_abs;
    logic [27:0]   op_a, op_b;
    logic [55:0]   pp;
    logic [PW-1:0] pp_sh;

    // operand magnitudes
    assign a_abs = a[ZW-1] ? ZW'(-a) : ZW'(a);
    assign b_abs = b[ZW-1] ? ZW'(-b) : ZW'(b);

    // partial product select: lo*lo, lo*hi, hi*lo, hi*hi
    assign op_a = cnt_reg[1] ? am_reg[55:28] : am_reg[27:0];
    assign op_b = cnt_reg[0] ? bm_reg[55:28] : bm_reg[27:0];
    assign pp   = op_a * op_b;

    always_comb
    begin
        case (cnt_reg)
            2'd0:    pp_sh = PW'(pp);
            2'd3:    pp_sh = PW'(pp) << 56;
            default: pp_sh = PW'(pp) << 28;
        endcase
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign mag  = acc_reg;
    assign neg  = neg_reg;

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            am_reg  <= a_abs[55:0];
            bm_reg  <= b_abs[55:0];
            neg_reg <= a[ZW-1] ^ b[ZW-1];
            acc_reg <= '0;
        end
        else if (busy_reg)
            acc_reg <= acc_reg + pp_sh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire
